// File: design/kped_pkg.sv
package kped_pkg;

    localparam int NumKeysDef    = 4;
    localparam int QueueDepthDef = 8;

    localparam int KeyW   = 2;
    localparam int CountW = 3;
    localparam int DbW    = 8;
    localparam int LpW    = 16;
    localparam int CfgIdxW = 2;

    localparam logic [DbW-1:0] DebounceRst = 8'd20;
    localparam logic [LpW-1:0] LongRst     = 16'd2000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_ACTIVE     = 2'd2,
        CFG_KEY_ENABLE = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_POP    = 1'b1
    } t_cmd;

    typedef enum logic {
        ACT_CLICK = 1'b0,
        ACT_LONG  = 1'b1
    } t_action;

    typedef struct packed {
        logic    push;
        t_action action;
    } t_lane_evt;

    typedef struct packed {
        logic              ev_valid;
        logic [KeyW-1:0]   ev_key;
        t_action           ev_action;
        logic              added;
        logic [CountW-1:0] count;
    } t_result;

endpackage

// File: design/kped_lane.sv
module kped_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_level,
    input  logic                         i_active,
    input  logic [kped_pkg::DbW-1:0]     i_debounce,
    input  logic [kped_pkg::LpW-1:0]     i_long_press,
    output kped_pkg::t_lane_evt          o_evt
);

    logic                     r_last, n_last;
    logic                     r_db_pend, n_db_pend;
    logic                     r_long_rep, n_long_rep;
    logic                     r_run, n_run;
    logic [kped_pkg::LpW-1:0] r_cnt, n_cnt;
    logic                     armed;
    logic                     click;
    logic                     long_evt;
    logic [kped_pkg::LpW-1:0] db_dur;
    logic [kped_pkg::LpW-1:0] lp_dur;

    assign db_dur = (i_debounce == '0) ? kped_pkg::LpW'(1)
                                       : kped_pkg::LpW'(i_debounce);
    assign lp_dur = (i_long_press == '0) ? kped_pkg::LpW'(1) : i_long_press;

    always_comb begin
        n_last     = i_level;
        n_db_pend  = r_db_pend;
        n_long_rep = r_long_rep;
        n_run      = r_run;
        n_cnt      = r_cnt;
        armed      = 1'b0;
        click      = 1'b0;
        long_evt   = 1'b0;
        if (r_last != i_active) begin
            if (i_level == i_active) begin
                n_db_pend  = 1'b1;
                n_long_rep = 1'b0;
                n_run      = 1'b1;
                n_cnt      = db_dur;
                armed      = 1'b1;
            end
        end else if (i_level != i_active) begin
            if (!r_long_rep && !r_db_pend) begin
                n_run = 1'b0;
                click = 1'b1;
            end
            n_db_pend = 1'b0;
        end
        if (n_run && !armed) begin
            n_cnt = n_cnt - 1'b1;
            if (n_cnt == '0) begin
                n_run = 1'b0;
                if (i_level == i_active) begin
                    if (!n_db_pend) begin
                        long_evt   = 1'b1;
                        n_long_rep = 1'b1;
                    end else begin
                        n_db_pend = 1'b0;
                        n_run     = 1'b1;
                        n_cnt     = lp_dur;
                    end
                end
            end
        end
    end

    always_comb begin
        o_evt.push   = i_en && (click || long_evt);
        o_evt.action = long_evt ? kped_pkg::ACT_LONG : kped_pkg::ACT_CLICK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 1'b1;
            r_db_pend  <= 1'b0;
            r_long_rep <= 1'b0;
            r_run      <= 1'b0;
            r_cnt      <= '0;
        end else if (i_en) begin
            r_last     <= n_last;
            r_db_pend  <= n_db_pend;
            r_long_rep <= n_long_rep;
            r_run      <= n_run;
            r_cnt      <= n_cnt;
        end
    end

endmodule

// File: design/kped_queue.sv
module kped_queue #(
    parameter int NUM_KEYS    = kped_pkg::NumKeysDef,
    parameter int QUEUE_DEPTH = kped_pkg::QueueDepthDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_pop,
    input  kped_pkg::t_lane_evt [NUM_KEYS-1:0] i_evt,
    output kped_pkg::t_result              o_result
);

    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int EntW  = kped_pkg::KeyW + 1;
    localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

    logic [EntW-1:0]          r_store [QUEUE_DEPTH];
    logic [PtrW-1:0]          r_rd, n_rd;
    logic [PtrW-1:0]          r_wr, n_wr;
    logic [PtrW-1:0]          slot [NUM_KEYS];
    logic [PtrW:0]            cnt_wide;
    logic [PtrW-1:0]          cnt;
    logic [PtrW+2:0]          cnt_ext;
    logic [EntW-1:0]          head;
    logic                     not_empty;
    logic                     any_push;

    assign not_empty = (r_rd != r_wr);
    assign head      = r_store[r_rd];

    always_comb begin
        logic [PtrW-1:0] rp;
        logic [PtrW-1:0] wp;
        logic [PtrW-1:0] nw;
        rp       = r_rd;
        wp       = r_wr;
        nw       = '0;
        any_push = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            slot[k] = wp;
            if (!i_pop && i_evt[k].push) begin
                any_push = 1'b1;
                nw = (wp == LastSlot) ? '0 : wp + 1'b1;
                if (nw == rp) begin
                    rp = '0;
                    wp = '0;
                    nw = PtrW'(1);
                end
                slot[k] = wp;
                wp      = nw;
            end
        end
        if (i_pop && not_empty) begin
            rp = (rp == LastSlot) ? '0 : rp + 1'b1;
        end
        n_rd = rp;
        n_wr = wp;
    end

    always_comb begin
        if (n_wr >= n_rd) begin
            cnt_wide = {1'b0, n_wr} - {1'b0, n_rd};
        end else begin
            cnt_wide = {1'b0, n_wr} + (PtrW+1)'(QUEUE_DEPTH) - {1'b0, n_rd};
        end
        cnt     = cnt_wide[PtrW-1:0];
        cnt_ext = (PtrW+3)'(cnt);
    end

    always_comb begin
        o_result.ev_valid  = i_pop && not_empty;
        o_result.ev_key    = (i_pop && not_empty) ? head[EntW-1:1] : '0;
        o_result.ev_action = (i_pop && not_empty) ? kped_pkg::t_action'(head[0])
                                                  : kped_pkg::ACT_CLICK;
        o_result.added     = !i_pop && any_push;
        o_result.count     = cnt_ext[kped_pkg::CountW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !i_pop) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (i_evt[k].push) begin
                    r_store[slot[k]] <= {kped_pkg::KeyW'(k), i_evt[k].action};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else if (i_step) begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

endmodule

// File: design/key_press_event_detector_top.sv
// Key press event detector.
// Input channel (i_in_valid / o_in_ready): one transaction per item; i_cmd
// selects a sample tick carrying i_key_levels, or a pop of one queued event.
// Output channel (o_out_valid / i_out_ready): exactly one result transaction
// per input transaction, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and data;
// always ready; user must write only while the block is idle (unenforced).
// Result: registered, it appears in the cycle after the input is accepted.
// Throughput: one item per cycle while o_in_ready is high; every key has its
// own lane and all lanes plus the ordered queue merge settle in the accepting cycle.
// Stall: the output register holds the result; a new item is taken in the
// same cycle the held one is taken, so o_in_ready drops only while a result
// waits and i_out_ready is low.
// Reset: synchronous, active low; registers but the event store and result
// return to their defaults; all keys idle, queue empty, no result pending.
module key_press_event_detector_top #(
    parameter int NUM_KEYS    = kped_pkg::NumKeysDef,
    parameter int QUEUE_DEPTH = kped_pkg::QueueDepthDef
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_cmd,
    input  logic [NUM_KEYS-1:0]                     i_key_levels,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_event_valid,
    output logic [kped_pkg::KeyW-1:0]               o_event_key,
    output logic                                    o_event_action,
    output logic                                    o_events_added,
    output logic [kped_pkg::CountW-1:0]             o_queue_count,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [kped_pkg::CfgIdxW-1:0]            i_cfg_index,
    input  logic [((NUM_KEYS > 16) ? NUM_KEYS : 16)-1:0] i_cfg_data
);

    logic [kped_pkg::DbW-1:0]          r_debounce;
    logic [kped_pkg::LpW-1:0]          r_long_press;
    logic                              r_active;
    logic [NUM_KEYS-1:0]               r_key_en;
    logic                              step;
    logic                              pop;
    logic                              r_out_valid;
    kped_pkg::t_result                 r_result;
    kped_pkg::t_result                 result;
    kped_pkg::t_lane_evt [NUM_KEYS-1:0] evt;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign pop         = (kped_pkg::t_cmd'(i_cmd) == kped_pkg::CMD_POP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= kped_pkg::DebounceRst;
            r_long_press <= kped_pkg::LongRst;
            r_active     <= 1'b0;
            r_key_en     <= '1;
        end else if (i_cfg_valid) begin
            unique case (kped_pkg::t_cfg_idx'(i_cfg_index))
                kped_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[kped_pkg::DbW-1:0];
                kped_pkg::CFG_LONG_PRESS: r_long_press <= i_cfg_data[kped_pkg::LpW-1:0];
                kped_pkg::CFG_ACTIVE:     r_active     <= i_cfg_data[0];
                kped_pkg::CFG_KEY_ENABLE: r_key_en     <= i_cfg_data[NUM_KEYS-1:0];
                default:                  r_active     <= r_active;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kped_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (step && !pop && r_key_en[k]),
            .i_level     (i_key_levels[k]),
            .i_active    (r_active),
            .i_debounce  (r_debounce),
            .i_long_press(r_long_press),
            .o_evt       (evt[k])
        );
    end

    kped_queue #(
        .NUM_KEYS   (NUM_KEYS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (pop),
        .i_evt   (evt),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_valid  = r_result.ev_valid;
    assign o_event_key    = r_result.ev_key;
    assign o_event_action = r_result.ev_action;
    assign o_events_added = r_result.added;
    assign o_queue_count  = r_result.count;

endmodule

// File: design/kped_checker.sv
module kped_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_event_valid,
    input logic [kped_pkg::KeyW-1:0]     o_event_key,
    input logic                          o_event_action,
    input logic                          o_events_added,
    input logic [kped_pkg::CountW-1:0]   o_queue_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_valid)
            && $stable(o_event_key) && $stable(o_event_action)
            && $stable(o_events_added) && $stable(o_queue_count))
        else $error("stalled transaction changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with no result pending");

    a_pop_or_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_event_valid && o_events_added))
        else $error("event delivered and added in one transaction");

    a_empty_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_event_key == '0 && !o_event_action)
        else $error("event fields set without event");

endmodule

bind key_press_event_detector_top kped_checker u_kped_checker (.*);
